>>> rtl/cbeq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbeq_pkg
// Shared constants, codes and types of the cascaded biquad equalizer.
// ----------------------------------------------------------------------------
package cbeq_pkg;

  // default configuration
  localparam int NUM_BANDS      = 7;
  localparam int MAX_CHANNELS   = 2;
  localparam int COEF_FRAC_BITS = 28;

  // fixed formats
  localparam int SIG_FRAC  = 12;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 32;
  localparam int SIG_W     = 32;
  localparam int HIST_W    = 48;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 50;
  localparam int NUM_COEFS = 5;
  localparam int OP_W      = 2;
  localparam int CH_W      = 3;
  localparam int BAND_W    = 3;
  localparam int SEL_W     = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_FILTER     = 2'd0;
  localparam logic [OP_W-1:0] OP_COEF_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR_BAND = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL  = 2'd3;

  // coefficient selects
  localparam logic [SEL_W-1:0] COEF_B0 = 3'd0;
  localparam logic [SEL_W-1:0] COEF_B1 = 3'd1;
  localparam logic [SEL_W-1:0] COEF_B2 = 3'd2;
  localparam logic [SEL_W-1:0] COEF_A1 = 3'd3;
  localparam logic [SEL_W-1:0] COEF_A2 = 3'd4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SIG_W-1:0]    sig_t;
  typedef logic signed [HIST_W-1:0]   hist_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // per-band control from the top level
  typedef struct packed {
    logic             coef_we;
    logic [SEL_W-1:0] coef_sel;
    coef_t            coef_val;
    logic             clear;
  } cell_ctrl_t;

  // signal handed from one band cell to the next
  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] ch;
    sig_t            data;
  } cell_link_t;

endpackage
`default_nettype wire

>>> rtl/cbeq_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbeq_in_if
// Request channel: samples, coefficient writes and history clears.
// ----------------------------------------------------------------------------
interface cbeq_in_if;
  logic                             valid;
  logic                             ready;
  logic [cbeq_pkg::OP_W-1:0]        operation;
  logic [cbeq_pkg::CH_W-1:0]        channel;
  cbeq_pkg::sample_t                sample_in;
  logic                             end_of_block;
  logic [cbeq_pkg::BAND_W-1:0]      band;
  logic [cbeq_pkg::SEL_W-1:0]       coef_select;
  cbeq_pkg::coef_t                  coef_value;

  modport source (
    output valid, operation, channel, sample_in, end_of_block, band, coef_select,
           coef_value,
    input  ready
  );

  modport sink (
    input  valid, operation, channel, sample_in, end_of_block, band, coef_select,
           coef_value,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/cbeq_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbeq_out_if
// Result channel: equalized samples.
// ----------------------------------------------------------------------------
interface cbeq_out_if;
  logic                      valid;
  logic                      ready;
  cbeq_pkg::sample_t         sample_out;
  logic [cbeq_pkg::CH_W-1:0] channel_out;
  logic                      end_of_block_out;

  modport source (
    output valid, sample_out, channel_out, end_of_block_out,
    input  ready
  );

  modport sink (
    input  valid, sample_out, channel_out, end_of_block_out,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/cbeq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbeq_cell
// One biquad section, transposed direct form II, with its own coefficients
// and per-channel history. The next cell gets the registered output y.
// ----------------------------------------------------------------------------
module cbeq_cell #(
  parameter int MAX_CHANNELS   = cbeq_pkg::MAX_CHANNELS,
  parameter int COEF_FRAC_BITS = cbeq_pkg::COEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cbeq_pkg::cell_ctrl_t ctrl,
  input  cbeq_pkg::cell_link_t link_in,
  output cbeq_pkg::cell_link_t link_out
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  cbeq_pkg::coef_t coef [cbeq_pkg::NUM_COEFS];
  cbeq_pkg::hist_t z1 [MAX_CHANNELS];
  cbeq_pkg::hist_t z2 [MAX_CHANNELS];

  logic                      v1;
  logic                      v2;
  logic                      v3;
  logic [cbeq_pkg::CH_W-1:0] ch;
  logic [IDX_W-1:0]          idx;
  cbeq_pkg::prod_t           p0;
  cbeq_pkg::prod_t           p1;
  cbeq_pkg::prod_t           p2;
  cbeq_pkg::prod_t           m3;
  cbeq_pkg::prod_t           m4;
  cbeq_pkg::sig_t            y;
  cbeq_pkg::acc_t            q1;
  cbeq_pkg::acc_t            q2;
  cbeq_pkg::acc_t            y_sum;
  cbeq_pkg::acc_t            z1_sum;
  cbeq_pkg::acc_t            z2_sum;

  // clamp to the 32-bit signal range
  function automatic cbeq_pkg::sig_t sat_sig(input cbeq_pkg::acc_t v);
    logic all1;
    logic all0;
    all1 = &v[cbeq_pkg::ACC_W-1:cbeq_pkg::SIG_W-1];
    all0 = ~|v[cbeq_pkg::ACC_W-1:cbeq_pkg::SIG_W-1];
    if (all1 || all0) begin
      return v[cbeq_pkg::SIG_W-1:0];
    end else if (v[cbeq_pkg::ACC_W-1]) begin
      return {1'b1, {(cbeq_pkg::SIG_W-1){1'b0}}};
    end else begin
      return {1'b0, {(cbeq_pkg::SIG_W-1){1'b1}}};
    end
  endfunction

  // clamp to the 48-bit history range
  function automatic cbeq_pkg::hist_t sat_hist(input cbeq_pkg::acc_t v);
    logic all1;
    logic all0;
    all1 = &v[cbeq_pkg::ACC_W-1:cbeq_pkg::HIST_W-1];
    all0 = ~|v[cbeq_pkg::ACC_W-1:cbeq_pkg::HIST_W-1];
    if (all1 || all0) begin
      return v[cbeq_pkg::HIST_W-1:0];
    end else if (v[cbeq_pkg::ACC_W-1]) begin
      return {1'b1, {(cbeq_pkg::HIST_W-1){1'b0}}};
    end else begin
      return {1'b0, {(cbeq_pkg::HIST_W-1){1'b1}}};
    end
  endfunction

  assign idx = ch[IDX_W-1:0];

  // coefficient registers, identity section after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < cbeq_pkg::NUM_COEFS; k++) begin
        coef[k] <= (k == int'(cbeq_pkg::COEF_B0)) ?
                   (cbeq_pkg::coef_t'(1) <<< COEF_FRAC_BITS) : '0;
      end
    end else if (ctrl.coef_we) begin
      coef[ctrl.coef_sel] <= ctrl.coef_val;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= link_in.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // feed-forward products, band output, feedback products
  always_comb begin
    y_sum = cbeq_pkg::acc_t'(p0 >>> COEF_FRAC_BITS) + cbeq_pkg::acc_t'(z1[idx]);
  end

  always_ff @(posedge clk) begin
    if (link_in.valid) begin
      ch <= link_in.ch;
      p0 <= coef[cbeq_pkg::COEF_B0] * link_in.data;
      p1 <= coef[cbeq_pkg::COEF_B1] * link_in.data;
      p2 <= coef[cbeq_pkg::COEF_B2] * link_in.data;
    end
    if (v1) begin
      y  <= sat_sig(y_sum);
      q1 <= cbeq_pkg::acc_t'(p1 >>> COEF_FRAC_BITS);
      q2 <= cbeq_pkg::acc_t'(p2 >>> COEF_FRAC_BITS);
    end
    if (v2) begin
      m3 <= coef[cbeq_pkg::COEF_A1] * y;
      m4 <= coef[cbeq_pkg::COEF_A2] * y;
    end
  end

  // history update, old z2 feeds the new z1
  always_comb begin
    z1_sum = q1 - cbeq_pkg::acc_t'(m3 >>> COEF_FRAC_BITS) + cbeq_pkg::acc_t'(z2[idx]);
    z2_sum = q2 - cbeq_pkg::acc_t'(m4 >>> COEF_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        z1[c] <= '0;
        z2[c] <= '0;
      end
    end else if (v3) begin
      z1[idx] <= sat_hist(z1_sum);
      z2[idx] <= sat_hist(z2_sum);
    end
  end

  // hand the band output to the next cell
  assign link_out.valid = v2;
  assign link_out.ch    = ch;
  assign link_out.data  = y;

endmodule
`default_nettype wire

>>> rtl/cascaded_biquad_equalizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cascaded_biquad_equalizer_unit
// Multi-band equalizer: a chain of biquad cells, one per band, with
// per-channel history, rounding and 16-bit saturation at the end.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req       in   valid/ready    operation, channel, sample_in, end_of_block,
//                                band, coef_select, coef_value
//  rsp       out  valid/ready    sample_out, channel_out, end_of_block_out
//  cfg       in   cfg_we         cfg_wdata (enable)
//
//  A filtered sample walks the cell chain band by band; one sample is in
//  the chain at a time, so a new one is taken only once the last result
//  has left the hold stage. Pass-through samples skip the chain and go
//  straight to the hold stage. Reset loads identity coefficients and zero
//  history at once. A result waiting on rsp does not block req; the next
//  sample is still taken and its result waits in the hold stage behind it.
// ----------------------------------------------------------------------------
module cascaded_biquad_equalizer_unit #(
  parameter int NUM_BANDS      = cbeq_pkg::NUM_BANDS,
  parameter int MAX_CHANNELS   = cbeq_pkg::MAX_CHANNELS,
  parameter int COEF_FRAC_BITS = cbeq_pkg::COEF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  cbeq_in_if.sink    req,
  cbeq_out_if.source rsp
);

  typedef logic signed [cbeq_pkg::SIG_W:0] rnd_t;
  localparam int RND_HALF = 1 << (cbeq_pkg::SIG_FRAC - 1);

  cbeq_pkg::cell_ctrl_t ctrl [NUM_BANDS];
  cbeq_pkg::cell_link_t link [NUM_BANDS+1];

  logic                      enable;
  logic                      busy;
  logic                      accept;
  logic                      is_filter;
  logic                      ch_ok;
  logic                      filt_go;
  logic                      pass_go;
  logic                      coef_we;
  logic                      band_clear;
  logic                      clear_all;
  logic                      chain_done;
  logic                      move;
  logic                      hold_valid;
  cbeq_pkg::sample_t         hold_sample;
  logic [cbeq_pkg::CH_W-1:0] hold_ch;
  logic                      hold_eob;
  logic                      out_valid;
  cbeq_pkg::sample_t         out_sample;
  logic [cbeq_pkg::CH_W-1:0] out_ch;
  logic                      out_eob;
  cbeq_pkg::sig_t            y_last;
  rnd_t                      rnd_sum;
  rnd_t                      rnd_q;
  cbeq_pkg::sample_t         rnd_sat;

  // request decode
  assign req.ready  = !busy;
  assign accept     = req.valid && req.ready;
  assign is_filter  = accept && (req.operation == cbeq_pkg::OP_FILTER);
  assign ch_ok      = int'(req.channel) < MAX_CHANNELS;
  assign filt_go    = is_filter && enable && ch_ok;
  assign pass_go    = is_filter && !(enable && ch_ok);
  assign coef_we    = accept && (req.operation == cbeq_pkg::OP_COEF_WRITE) &&
                      (int'(req.band) < NUM_BANDS) &&
                      (req.coef_select <= cbeq_pkg::COEF_A2);
  assign band_clear = accept && (req.operation == cbeq_pkg::OP_CLEAR_BAND);
  assign clear_all  = (accept && (req.operation == cbeq_pkg::OP_CLEAR_ALL)) ||
                      (cfg_we && cfg_wdata && !enable);

  // enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_we) begin
      enable <= cfg_wdata;
    end
  end

  // per-band control
  always_comb begin
    for (int k = 0; k < NUM_BANDS; k++) begin
      ctrl[k].coef_we  = coef_we && (int'(req.band) == k);
      ctrl[k].coef_sel = req.coef_select;
      ctrl[k].coef_val = req.coef_value;
      ctrl[k].clear    = clear_all || (band_clear && (int'(req.band) == k));
    end
  end

  // chain input, sample scaled to the signal format
  assign link[0].valid = filt_go;
  assign link[0].ch    = req.channel;
  assign link[0].data  = cbeq_pkg::sig_t'(req.sample_in) <<< cbeq_pkg::SIG_FRAC;

  // band cells
  for (genvar k = 0; k < NUM_BANDS; k++) begin : g_band
    cbeq_cell #(
      .MAX_CHANNELS  (MAX_CHANNELS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl[k]),
      .link_in (link[k]),
      .link_out(link[k+1])
    );
  end

  // round to nearest, ties away from zero, then clamp to 16 bits
  assign chain_done = link[NUM_BANDS].valid;
  assign y_last     = link[NUM_BANDS].data;

  always_comb begin
    rnd_sum = rnd_t'(y_last) + (y_last[cbeq_pkg::SIG_W-1] ? rnd_t'(RND_HALF - 1) :
                                                            rnd_t'(RND_HALF));
    rnd_q   = rnd_sum >>> cbeq_pkg::SIG_FRAC;
    if ((&rnd_q[cbeq_pkg::SIG_W:cbeq_pkg::SAMPLE_W-1]) ||
        (~|rnd_q[cbeq_pkg::SIG_W:cbeq_pkg::SAMPLE_W-1])) begin
      rnd_sat = rnd_q[cbeq_pkg::SAMPLE_W-1:0];
    end else if (rnd_q[cbeq_pkg::SIG_W]) begin
      rnd_sat = {1'b1, {(cbeq_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      rnd_sat = {1'b0, {(cbeq_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

  // result hold stage, frees the chain while rsp is stalled
  assign move = hold_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      busy       <= 1'b0;
    end else begin
      if (pass_go || chain_done) begin
        hold_valid <= 1'b1;
      end else if (move) begin
        hold_valid <= 1'b0;
      end
      if (is_filter) begin
        busy <= 1'b1;
      end else if (move) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_filter) begin
      hold_ch  <= req.channel;
      hold_eob <= req.end_of_block;
    end
    if (pass_go) begin
      hold_sample <= req.sample_in;
    end else if (chain_done) begin
      hold_sample <= rnd_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_sample <= hold_sample;
      out_ch     <= hold_ch;
      out_eob    <= hold_eob;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.sample_out       = out_sample;
  assign rsp.channel_out      = out_ch;
  assign rsp.end_of_block_out = out_eob;

endmodule
`default_nettype wire

>>> dv/cascaded_biquad_equalizer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascaded_biquad_equalizer_unit_tb
// Self-checking bench for the seven-band biquad equalizer. A predictor
// class keeps its own coefficients, per-channel band history and enable
// bit, works out every equalized sample and checks the response channel in
// order. Directed transactions cover pass-through, saturation, ignored
// writes and clears. Random phases follow, with bursty requests and a
// stalling receiver.
// ----------------------------------------------------------------------------
module cascaded_biquad_equalizer_unit_tb;

  localparam int SETTLE_CYCLES   = 40;
  localparam int STALL_LIMIT     = 2000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 60;

  typedef logic [cbeq_pkg::OP_W-1:0]   op_t;
  typedef logic [cbeq_pkg::CH_W-1:0]   chan_t;
  typedef logic [cbeq_pkg::BAND_W-1:0] band_t;
  typedef logic [cbeq_pkg::SEL_W-1:0]  sel_t;

  typedef struct {
    op_t               op;
    chan_t             ch;
    cbeq_pkg::sample_t smp;
    logic              eob;
    band_t             band;
    sel_t              sel;
    cbeq_pkg::coef_t   cv;
  } eq_request_t;

  typedef struct {
    cbeq_pkg::sample_t smp;
    chan_t             ch;
    logic              eob;
  } eq_sample_t;

  // predictor of the band chain and store of outstanding samples
  class biquad_chain_predictor;
    localparam longint HIST_MAX = (longint'(1) <<< (cbeq_pkg::HIST_W - 1)) - 1;
    localparam longint HIST_MIN = -HIST_MAX - 1;
    localparam longint SIG_MAX  = (longint'(1) <<< (cbeq_pkg::SIG_W - 1)) - 1;
    localparam longint SIG_MIN  = -SIG_MAX - 1;

    cbeq_pkg::coef_t coefs [cbeq_pkg::NUM_BANDS*cbeq_pkg::NUM_COEFS];
    cbeq_pkg::hist_t z_one [cbeq_pkg::MAX_CHANNELS*cbeq_pkg::NUM_BANDS];
    cbeq_pkg::hist_t z_two [cbeq_pkg::MAX_CHANNELS*cbeq_pkg::NUM_BANDS];
    logic            enabled;
    eq_sample_t      pending_samples[$];
    int              errors;

    function new();
      for (int i = 0; i < cbeq_pkg::NUM_BANDS*cbeq_pkg::NUM_COEFS; i++)
        coefs[i] = (i % cbeq_pkg::NUM_COEFS == cbeq_pkg::COEF_B0) ?
                   cbeq_pkg::coef_t'(1 <<< cbeq_pkg::COEF_FRAC_BITS) : '0;
      clear_history();
      enabled = 1'b0;
      errors  = 0;
    endfunction

    function void clear_history();
      foreach (z_one[i]) begin
        z_one[i] = '0;
        z_two[i] = '0;
      end
    endfunction

    // a rising enable wipes all history
    function void set_enable(logic v);
      if (v && !enabled) clear_history();
      enabled = v;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // exact product, then floor shift back to signal scale
    function longint coef_mul(cbeq_pkg::coef_t c, longint x);
      return (longint'(c) * x) >>> cbeq_pkg::COEF_FRAC_BITS;
    endfunction

    function cbeq_pkg::sample_t equalize(chan_t ch, cbeq_pkg::sample_t smp);
      longint s, y, r, half;
      int     h, q;
      s = longint'(smp) <<< cbeq_pkg::SIG_FRAC;
      for (int b = 0; b < cbeq_pkg::NUM_BANDS; b++) begin
        h = int'(ch) * cbeq_pkg::NUM_BANDS + b;
        q = b * cbeq_pkg::NUM_COEFS;
        y = clip(coef_mul(coefs[q + int'(cbeq_pkg::COEF_B0)], s) + longint'(z_one[h]),
                 SIG_MIN, SIG_MAX);
        z_one[h] = cbeq_pkg::hist_t'(clip(coef_mul(coefs[q + int'(cbeq_pkg::COEF_B1)], s)
                                - coef_mul(coefs[q + int'(cbeq_pkg::COEF_A1)], y)
                                + longint'(z_two[h]), HIST_MIN, HIST_MAX));
        z_two[h] = cbeq_pkg::hist_t'(clip(coef_mul(coefs[q + int'(cbeq_pkg::COEF_B2)], s)
                                - coef_mul(coefs[q + int'(cbeq_pkg::COEF_A2)], y),
                                HIST_MIN, HIST_MAX));
        s = y;
      end
      // round half away from zero
      half = longint'(1) <<< (cbeq_pkg::SIG_FRAC - 1);
      if (s >= 0) r = (s + half) / (longint'(1) <<< cbeq_pkg::SIG_FRAC);
      else r = -((-s + half) / (longint'(1) <<< cbeq_pkg::SIG_FRAC));
      return cbeq_pkg::sample_t'(clip(r, longint'(-32768), longint'(32767)));
    endfunction

    function void take_request(eq_request_t r);
      eq_sample_t res;
      case (r.op)
        cbeq_pkg::OP_COEF_WRITE: begin
          if (r.band < cbeq_pkg::NUM_BANDS && r.sel < cbeq_pkg::NUM_COEFS)
            coefs[int'(r.band) * cbeq_pkg::NUM_COEFS + int'(r.sel)] = r.cv;
        end
        cbeq_pkg::OP_CLEAR_BAND: begin
          if (r.band < cbeq_pkg::NUM_BANDS)
            for (int c = 0; c < cbeq_pkg::MAX_CHANNELS; c++) begin
              z_one[c * cbeq_pkg::NUM_BANDS + int'(r.band)] = '0;
              z_two[c * cbeq_pkg::NUM_BANDS + int'(r.band)] = '0;
            end
        end
        cbeq_pkg::OP_CLEAR_ALL: clear_history();
        cbeq_pkg::OP_FILTER: begin
          if (enabled && r.ch < cbeq_pkg::MAX_CHANNELS) res.smp = equalize(r.ch, r.smp);
          else res.smp = r.smp;
          res.ch  = r.ch;
          res.eob = r.eob;
          pending_samples.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void compare_sample(eq_sample_t got);
      eq_sample_t want;
      if (pending_samples.size() == 0) begin
        $error("unexpected transaction: sample_out %0d channel_out %0d", got.smp, got.ch);
        errors++;
        return;
      end
      want = pending_samples.pop_front();
      if (got.smp !== want.smp) begin
        $error("sample_out: expected %0d, got %0d", want.smp, got.smp);
        errors++;
      end
      if (got.ch !== want.ch) begin
        $error("channel_out: expected %0d, got %0d", want.ch, got.ch);
        errors++;
      end
      if (got.eob !== want.eob) begin
        $error("end_of_block_out: expected %0d, got %0d", want.eob, got.eob);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  cbeq_in_if  req_if ();
  cbeq_out_if rsp_if ();

  biquad_chain_predictor chain = new();

  int   burst_left   = 0;
  int   ready_run    = 0;
  logic ready_level  = 1'b0;
  int   quiet_cycles = 0;

  cascaded_biquad_equalizer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  always #1 clk = ~clk;

  // watch both channels and the register port at the rising edge
  always @(posedge clk) begin : port_monitor
    eq_request_t r;
    eq_sample_t  s;
    if (!rst) begin
      if (cfg_we) chain.set_enable(cfg_wdata);
      if (rsp_if.valid && rsp_if.ready) begin
        s.smp = rsp_if.sample_out;
        s.ch  = rsp_if.channel_out;
        s.eob = rsp_if.end_of_block_out;
        chain.compare_sample(s);
      end
      if (req_if.valid && req_if.ready) begin
        r.op   = req_if.operation;
        r.ch   = req_if.channel;
        r.smp  = req_if.sample_in;
        r.eob  = req_if.end_of_block;
        r.band = req_if.band;
        r.sel  = req_if.coef_select;
        r.cv   = req_if.coef_value;
        chain.take_request(r);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || cfg_we || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: runs of ready and stall of random length
  always @(negedge clk) begin
    if (ready_run == 0) begin
      ready_level = ($urandom_range(0, 2) != 0);
      ready_run   = ready_level ? $urandom_range(1, 40) : $urandom_range(1, 24);
    end
    ready_run = ready_run - 1;
    rsp_if.ready <= ready_level;
  end

  function automatic eq_request_t junk_fields();
    eq_request_t r;
    r.op   = op_t'($urandom_range(0, 3));
    r.ch   = chan_t'($urandom_range(0, 7));
    r.smp  = cbeq_pkg::sample_t'($urandom);
    r.eob  = 1'($urandom_range(0, 1));
    r.band = band_t'($urandom_range(0, 7));
    r.sel  = sel_t'($urandom_range(0, 7));
    r.cv   = cbeq_pkg::coef_t'($urandom);
    return r;
  endfunction

  function automatic eq_request_t sample_req(chan_t ch, cbeq_pkg::sample_t smp, logic eob);
    eq_request_t r;
    r     = junk_fields();
    r.op  = cbeq_pkg::OP_FILTER;
    r.ch  = ch;
    r.smp = smp;
    r.eob = eob;
    return r;
  endfunction

  function automatic eq_request_t coef_req(band_t band, sel_t sel, cbeq_pkg::coef_t cv);
    eq_request_t r;
    r      = junk_fields();
    r.op   = cbeq_pkg::OP_COEF_WRITE;
    r.band = band;
    r.sel  = sel;
    r.cv   = cv;
    return r;
  endfunction

  function automatic eq_request_t clear_req(op_t op, band_t band);
    eq_request_t r;
    r      = junk_fields();
    r.op   = op;
    r.band = band;
    return r;
  endfunction

  // mild coefficient: b0 near unity, the rest within +-1/8
  function automatic cbeq_pkg::coef_t gentle_coef(sel_t sel);
    int offset;
    offset = $urandom_range(0, 1 << 26);
    offset = offset - (1 << 25);
    if (sel == cbeq_pkg::COEF_B0)
      return cbeq_pkg::coef_t'((1 <<< cbeq_pkg::COEF_FRAC_BITS) + offset);
    return cbeq_pkg::coef_t'(offset);
  endfunction

  function automatic eq_request_t rand_request();
    int          pick;
    eq_request_t r;
    pick = $urandom_range(0, 99);
    r    = junk_fields();
    if (pick < 78) begin
      r.op = cbeq_pkg::OP_FILTER;
      if ($urandom_range(0, 7) != 0)
        r.ch = chan_t'($urandom_range(0, cbeq_pkg::MAX_CHANNELS - 1));
      case ($urandom_range(0, 15))
        0: r.smp = 16'sh7fff;
        1: r.smp = 16'sh8000;
        2: r.smp = '0;
        3: r.smp = '1;
        default: ;
      endcase
    end else if (pick < 92) begin
      r.op = cbeq_pkg::OP_COEF_WRITE;
      if ($urandom_range(0, 7) != 0)
        r.band = band_t'($urandom_range(0, cbeq_pkg::NUM_BANDS - 1));
      if ($urandom_range(0, 7) != 0)
        r.sel = sel_t'($urandom_range(0, cbeq_pkg::NUM_COEFS - 1));
      if ($urandom_range(0, 5) != 0) r.cv = gentle_coef(r.sel);
    end else if (pick < 97) begin
      r.op = cbeq_pkg::OP_CLEAR_BAND;
    end else begin
      r.op = cbeq_pkg::OP_CLEAR_ALL;
    end
    return r;
  endfunction

  // one request transaction; the sender works in bursts with gaps between
  task automatic send_request(input eq_request_t r);
    req_if.valid        <= 1'b1;
    req_if.operation    <= r.op;
    req_if.channel      <= r.ch;
    req_if.sample_in    <= r.smp;
    req_if.end_of_block <= r.eob;
    req_if.band         <= r.band;
    req_if.coef_select  <= r.sel;
    req_if.coef_value   <= r.cv;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // let every outstanding sample and any trailing operation finish
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (chain.pending_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_enable(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_gentle_set();
    for (int b = 0; b < cbeq_pkg::NUM_BANDS; b++)
      for (int k = 0; k < cbeq_pkg::NUM_COEFS; k++)
        send_request(coef_req(band_t'(b), sel_t'(k), gentle_coef(sel_t'(k))));
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = 1'b0;
    req_if.valid        = 1'b0;
    req_if.operation    = cbeq_pkg::OP_FILTER;
    req_if.channel      = '0;
    req_if.sample_in    = '0;
    req_if.end_of_block = 1'b0;
    req_if.band         = '0;
    req_if.coef_select  = cbeq_pkg::COEF_B0;
    req_if.coef_value   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // disabled: pass-through, while writes and clears still land
    send_request(sample_req(chan_t'(0), 16'sh7fff, 1'b1));
    send_request(sample_req(chan_t'(1), 16'sh8000, 1'b0));
    send_request(sample_req(chan_t'(7), '0, 1'b1));
    send_request(coef_req(band_t'(0), cbeq_pkg::COEF_B0, 32'sh2000_0000));
    send_request(clear_req(cbeq_pkg::OP_CLEAR_BAND, band_t'(3)));
    send_request(clear_req(cbeq_pkg::OP_CLEAR_ALL, band_t'(0)));
    wait_idle();
    write_enable(1'b1);

    // gain of two on the first band drives the output into saturation
    send_request(sample_req(chan_t'(0), 16'sh7fff, 1'b0));
    send_request(sample_req(chan_t'(1), 16'sh8000, 1'b1));
    send_request(sample_req(chan_t'(1), 16'sh0001, 1'b0));
    // writes to a missing band or coefficient are dropped
    send_request(coef_req(band_t'(7), cbeq_pkg::COEF_B0, 32'sh0));
    send_request(coef_req(band_t'(2), 3'd5, 32'sh0));
    send_request(coef_req(band_t'(2), 3'd7, 32'sh7fff_ffff));
    // extreme coefficients
    send_request(coef_req(band_t'(6), cbeq_pkg::COEF_A1, 32'sh8000_0000));
    send_request(coef_req(band_t'(6), cbeq_pkg::COEF_A2, 32'sh7fff_ffff));
    send_request(coef_req(band_t'(5), cbeq_pkg::COEF_B2, 32'sh8000_0000));
    send_request(coef_req(band_t'(4), cbeq_pkg::COEF_B1, 32'sh7fff_ffff));
    send_request(sample_req(chan_t'(0), 16'sh7fff, 1'b1));
    send_request(sample_req(chan_t'(0), 16'sh8000, 1'b0));
    send_request(sample_req(chan_t'(1), 16'sh7fff, 1'b0));
    send_request(sample_req(chan_t'(1), 16'sh0000, 1'b1));
    // channels beyond the last one pass through untouched
    send_request(sample_req(chan_t'(2), 16'sh3039, 1'b0));
    send_request(sample_req(chan_t'(7), 16'shffff, 1'b1));
    send_request(clear_req(cbeq_pkg::OP_CLEAR_BAND, band_t'(7)));
    send_request(clear_req(cbeq_pkg::OP_CLEAR_BAND, band_t'(6)));
    send_request(sample_req(chan_t'(0), 16'sh1234, 1'b0));

    // random phases under changing enable settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_enable(p % 3 != 2);
      if (p % 2 == 0) load_gentle_set();
      repeat (ITEMS_PER_PHASE) send_request(rand_request());
    end

    wait_idle();
    if (chain.errors == 0 && chain.pending_samples.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cbeq_pkg.sv
rtl/cbeq_in_if.sv
rtl/cbeq_out_if.sv
rtl/cbeq_cell.sv
rtl/cascaded_biquad_equalizer_unit.sv
dv/cascaded_biquad_equalizer_unit_tb.sv
